[sv/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked property, suspended while reset is applied.
`define SHDES_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("shdes assertion failed");
// Checked property, also sampled during reset.
`define SHDES_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("shdes assertion failed");
`else
`define SHDES_ASSERT(lbl, clk, rst_n, prop)
`define SHDES_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[sv/shdes_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// shdes_pkg
// Types, DES tables and permutation functions for the salted DES hash.
// ---------------------------------------------------------------------------
package shdes_pkg;

  localparam logic [63:0] PLAIN_BLOCK = 64'h5041535357442121;
  localparam logic [7:0]  ITER_RESET  = 8'd25;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       load;
    logic       round_en;
    logic       last_round;
    logic       capture;
    logic [3:0] round;
  } dp_cmd_t;

  localparam logic [6:0] IP_TAB [64] = '{
    7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,7'd10,7'd2, 7'd60,7'd52,7'd44,7'd36,7'd28,7'd20,7'd12,7'd4,
    7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,7'd14,7'd6, 7'd64,7'd56,7'd48,7'd40,7'd32,7'd24,7'd16,7'd8,
    7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9,7'd1,  7'd59,7'd51,7'd43,7'd35,7'd27,7'd19,7'd11,7'd3,
    7'd61,7'd53,7'd45,7'd37,7'd29,7'd21,7'd13,7'd5, 7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15,7'd7};
  localparam logic [6:0] FP_TAB [64] = '{
    7'd40,7'd8,7'd48,7'd16,7'd56,7'd24,7'd64,7'd32, 7'd39,7'd7,7'd47,7'd15,7'd55,7'd23,7'd63,7'd31,
    7'd38,7'd6,7'd46,7'd14,7'd54,7'd22,7'd62,7'd30, 7'd37,7'd5,7'd45,7'd13,7'd53,7'd21,7'd61,7'd29,
    7'd36,7'd4,7'd44,7'd12,7'd52,7'd20,7'd60,7'd28, 7'd35,7'd3,7'd43,7'd11,7'd51,7'd19,7'd59,7'd27,
    7'd34,7'd2,7'd42,7'd10,7'd50,7'd18,7'd58,7'd26, 7'd33,7'd1,7'd41,7'd9,7'd49,7'd17,7'd57,7'd25};
  localparam logic [5:0] E_TAB [48] = '{
    6'd32,6'd1,6'd2,6'd3,6'd4,6'd5, 6'd4,6'd5,6'd6,6'd7,6'd8,6'd9,
    6'd8,6'd9,6'd10,6'd11,6'd12,6'd13, 6'd12,6'd13,6'd14,6'd15,6'd16,6'd17,
    6'd16,6'd17,6'd18,6'd19,6'd20,6'd21, 6'd20,6'd21,6'd22,6'd23,6'd24,6'd25,
    6'd24,6'd25,6'd26,6'd27,6'd28,6'd29, 6'd28,6'd29,6'd30,6'd31,6'd32,6'd1};
  localparam logic [5:0] P_TAB [32] = '{
    6'd16,6'd7,6'd20,6'd21,6'd29,6'd12,6'd28,6'd17, 6'd1,6'd15,6'd23,6'd26,6'd5,6'd18,6'd31,6'd10,
    6'd2,6'd8,6'd24,6'd14,6'd32,6'd27,6'd3,6'd9,    6'd19,6'd13,6'd30,6'd6,6'd22,6'd11,6'd4,6'd25};
  localparam logic [6:0] PC1_TAB [56] = '{
    7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9, 7'd1,7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,
    7'd10,7'd2,7'd59,7'd51,7'd43,7'd35,7'd27, 7'd19,7'd11,7'd3,7'd60,7'd52,7'd44,7'd36,
    7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15, 7'd7,7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,
    7'd14,7'd6,7'd61,7'd53,7'd45,7'd37,7'd29, 7'd21,7'd13,7'd5,7'd28,7'd20,7'd12,7'd4};
  localparam logic [5:0] PC2_TAB [48] = '{
    6'd14,6'd17,6'd11,6'd24,6'd1,6'd5, 6'd3,6'd28,6'd15,6'd6,6'd21,6'd10,
    6'd23,6'd19,6'd12,6'd4,6'd26,6'd8, 6'd16,6'd7,6'd27,6'd20,6'd13,6'd2,
    6'd41,6'd52,6'd31,6'd37,6'd47,6'd55, 6'd30,6'd40,6'd51,6'd45,6'd33,6'd48,
    6'd44,6'd49,6'd39,6'd56,6'd34,6'd53, 6'd46,6'd42,6'd50,6'd36,6'd29,6'd32};
  // Rounds that shift the key halves by two places.
  localparam logic [15:0] ROT2_MASK = 16'b0111_1110_1111_1100;

  localparam logic [3:0] SBOX [8][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

  // Table entries count bits from 1 at the top.
  function automatic logic [63:0] perm_ip(input logic [63:0] x);
    logic [63:0] r;
    for (int k = 0; k < 64; k++) r[63-k] = x[6'(7'd64 - IP_TAB[k])];
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] x);
    logic [63:0] r;
    for (int k = 0; k < 64; k++) r[63-k] = x[6'(7'd64 - FP_TAB[k])];
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] x);
    logic [55:0] r;
    for (int k = 0; k < 56; k++) r[55-k] = x[6'(7'd64 - PC1_TAB[k])];
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] x);
    logic [47:0] r;
    for (int k = 0; k < 48; k++) r[47-k] = x[6'(6'd56 - PC2_TAB[k])];
    return r;
  endfunction

  function automatic logic [27:0] rot28(input logic [27:0] v, input logic two);
    return two ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] e;
    logic [31:0] o;
    logic [31:0] p;
    logic [5:0]  six;
    for (int k2 = 0; k2 < 48; k2++) e[47-k2] = r[5'(6'd32 - E_TAB[k2])];
    e = e ^ k;
    for (int j = 0; j < 8; j++) begin
      six = e[47-6*j -: 6];
      o[31-4*j -: 4] = SBOX[j][{six[5], six[0], six[4:1]}];
    end
    for (int k3 = 0; k3 < 32; k3++) p[31-k3] = o[5'(6'd32 - P_TAB[k3])];
    return p;
  endfunction

endpackage
`default_nettype wire

[sv/shdes_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// shdes_in_if / shdes_out_if
// Valid/ready channels for hash requests and hash results.
// ---------------------------------------------------------------------------
interface shdes_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] password_key;
  logic [15:0] salt;
  logic [15:0] expected_salt;
  logic [63:0] expected_hash;
  modport source (output valid, password_key, salt, expected_salt, expected_hash,
                  input ready);
  modport sink (input valid, password_key, salt, expected_salt, expected_hash,
                output ready);
endinterface

interface shdes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;
  logic        matches_res;
  modport source (output valid, hash_value, matches_res, input ready);
  modport sink (input valid, hash_value, matches_res, output ready);
endinterface
`default_nettype wire

[sv/shdes_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// shdes_dp
// DES round datapath: key halves, block halves and the result register.
// ---------------------------------------------------------------------------
module shdes_dp (
  input  wire logic             clk,
  input  wire shdes_pkg::dp_cmd_t cmd,
  input  wire logic [63:0]      password_key,
  input  wire logic [15:0]      salt,
  input  wire logic [15:0]      expected_salt,
  input  wire logic [63:0]      expected_hash,
  output logic [63:0]           hash_value,
  output logic                  matches_res
);
  import shdes_pkg::*;

  logic [27:0] c_r, c_nxt, d_r, d_nxt;
  logic [31:0] l_r, l_nxt, r_r, r_nxt;
  logic        salt_eq_r, salt_eq_nxt;
  logic [63:0] ehash_r, ehash_nxt;
  logic [63:0] hash_r, hash_nxt;
  logic        match_r, match_nxt;
  logic [55:0] cd_load;
  logic [63:0] ip_plain;
  logic [27:0] c_rot, d_rot;
  logic [31:0] t;
  logic [63:0] fp_out;

  always_comb begin
    cd_load  = perm_pc1(password_key ^ {salt, 48'd0});
    ip_plain = perm_ip(PLAIN_BLOCK);
    c_rot    = rot28(c_r, ROT2_MASK[cmd.round]);
    d_rot    = rot28(d_r, ROT2_MASK[cmd.round]);
    t        = l_r ^ feistel(r_r, perm_pc2({c_rot, d_rot}));
    // halves are kept swapped after the last round, so FP of {l, r} is the block
    fp_out   = perm_fp({l_r, r_r});

    c_nxt = c_r; d_nxt = d_r; l_nxt = l_r; r_nxt = r_r;
    salt_eq_nxt = salt_eq_r; ehash_nxt = ehash_r;
    hash_nxt = hash_r; match_nxt = match_r;
    if (cmd.load) begin
      c_nxt       = cd_load[55:28];
      d_nxt       = cd_load[27:0];
      l_nxt       = ip_plain[63:32];
      r_nxt       = ip_plain[31:0];
      salt_eq_nxt = (salt == expected_salt);
      ehash_nxt   = expected_hash;
    end else if (cmd.round_en) begin
      c_nxt = c_rot;
      d_nxt = d_rot;
      if (cmd.last_round) begin
        // swap so the next encryption starts straight from IP(FP(x)) = x
        l_nxt = t;
        r_nxt = r_r;
      end else begin
        l_nxt = r_r;
        r_nxt = t;
      end
    end
    if (cmd.capture) begin
      hash_nxt  = fp_out;
      match_nxt = salt_eq_r && (fp_out == ehash_r);
    end
  end

  always_ff @(posedge clk) begin
    c_r       <= c_nxt;
    d_r       <= d_nxt;
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    salt_eq_r <= salt_eq_nxt;
    ehash_r   <= ehash_nxt;
    hash_r    <= hash_nxt;
    match_r   <= match_nxt;
  end

  assign hash_value  = hash_r;
  assign matches_res = match_r;

endmodule
`default_nettype wire

[sv/shdes_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// shdes_ctrl
// Sequencer: round and iteration counters, handshakes, iteration register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module shdes_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  output shdes_pkg::dp_cmd_t cmd
);
  import shdes_pkg::*;

  state_t      state_r, state_nxt;
  logic [3:0]  round_r, round_nxt;
  logic [7:0]  iter_r, iter_nxt;
  logic [7:0]  cfg_r, cfg_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_r     <= '0;
      iter_r      <= '0;
      cfg_r       <= ITER_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      iter_r      <= iter_nxt;
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    round_nxt      = round_r;
    iter_nxt       = iter_r;
    cfg_nxt        = cfg_we ? cfg_wdata : cfg_r;
    cmd            = '0;
    cmd.round      = round_r;
    cmd.last_round = (round_r == 4'd15);
    in_ready       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          iter_nxt  = cfg_r;
          round_nxt = '0;
          state_nxt = (cfg_r == 8'd0) ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.round_en = 1'b1;
        round_nxt    = round_r + 4'd1;
        if (cmd.last_round) begin
          iter_nxt = iter_r - 8'd1;
          if (iter_r == 8'd1) state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait for the result register to be free
        if (!out_valid_r || out_ready) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    priority if (cmd.capture)              out_valid_nxt = 1'b1;
    else if (out_valid_r && out_ready)     out_valid_nxt = 1'b0;
    else                                   out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

  `SHDES_ASSERT(a_load_idle, clk, rst_n, cmd.load |-> state_r == ST_IDLE)
  `SHDES_ASSERT(a_no_overwrite, clk, rst_n, cmd.capture |-> (!out_valid_r || out_ready))
  `SHDES_ASSERT(a_round_zero_idle, clk, rst_n, state_r == ST_IDLE |-> round_r == 4'd0)
  `SHDES_ASSERT(a_capture_valid, clk, rst_n, cmd.capture |=> out_valid_r)

endmodule
`default_nettype wire

[sv/salted_iterated_des_password_hash.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// salted_iterated_des_password_hash
// Salted, chained DES-ECB password hash with a compare against a stored pair.
// ---------------------------------------------------------------------------
// A request is loaded, then runs N chained encryptions of 16 DES rounds, N
// being the iteration count (default 25), one DES round per cycle in the
// shared round unit, before the result is registered. A new request is
// taken once the previous result is registered; the result waits in its
// own register until transferred.
module salted_iterated_des_password_hash (
  input  wire logic       clk,
  input  wire logic       rst_n,
  shdes_in_if.sink        in_ch,
  shdes_out_if.source     out_ch,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);
  import shdes_pkg::*;

  dp_cmd_t cmd;

  shdes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd)
  );

  shdes_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .password_key  (in_ch.password_key),
    .salt          (in_ch.salt),
    .expected_salt (in_ch.expected_salt),
    .expected_hash (in_ch.expected_hash),
    .hash_value    (out_ch.hash_value),
    .matches_res   (out_ch.matches_res)
  );

endmodule
`default_nettype wire

[test/tb_salted_iterated_des_password_hash.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_salted_iterated_des_password_hash
// Drives password requests through the salted DES hash and compares every
// result against an in-bench DES computation, across iteration counts and
// with random gaps on both channels.
// ---------------------------------------------------------------------------
module tb_salted_iterated_des_password_hash;
  import shdes_pkg::*;

  typedef struct packed {
    logic [63:0] hash_value;
    logic        matches_res;
  } hash_result_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  shdes_in_if  in_ch ();
  shdes_out_if out_ch ();

  salted_iterated_des_password_hash uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  hash_result_t hash_queue[$];
  logic [7:0]   iter_cnt;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           hold_off;
  int           errors;
  int           n_sent;
  int           n_checked;
  int           n_matched;

  localparam int ROT_TAB [16] = '{1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic [31:0] round_f(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] e;
    logic [31:0] o;
    logic [31:0] p;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) e[47-i] = r[32 - E_TAB[i]];
    e ^= k;
    for (int j = 0; j < 8; j++) begin
      six = e[47-6*j -: 6];
      o[31-4*j -: 4] = SBOX[j][{six[5], six[0]} * 16 + six[4:1]];
    end
    for (int i = 0; i < 32; i++) p[31-i] = o[32 - P_TAB[i]];
    return p;
  endfunction

  function automatic hash_result_t compute_hash(input logic [63:0] pkey,
      input logic [15:0] salt, input logic [15:0] esalt, input logic [63:0] ehash,
      input logic [7:0] n);
    logic [63:0] key;
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    logic [47:0] sub [16];
    logic [63:0] blk;
    logic [63:0] x;
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] t;
    hash_result_t res;
    key = pkey ^ {salt, 48'h0};
    for (int i = 0; i < 56; i++) cd[55-i] = key[64 - PC1_TAB[i]];
    c = cd[55:28];
    d = cd[27:0];
    for (int i = 0; i < 16; i++) begin
      for (int s = 0; s < ROT_TAB[i]; s++) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      cd = {c, d};
      for (int b = 0; b < 48; b++) sub[i][47-b] = cd[56 - PC2_TAB[b]];
    end
    blk = PLAIN_BLOCK;
    for (int it = 0; it < n; it++) begin
      for (int b = 0; b < 64; b++) x[63-b] = blk[64 - IP_TAB[b]];
      l = x[63:32];
      r = x[31:0];
      for (int i = 0; i < 16; i++) begin
        t = l ^ round_f(r, sub[i]);
        l = r;
        r = t;
      end
      x = {r, l};
      for (int b = 0; b < 64; b++) blk[63-b] = x[64 - FP_TAB[b]];
    end
    res.hash_value  = blk;
    res.matches_res = (salt == esalt) && (blk == ehash);
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_request(input logic [63:0] pkey, input logic [15:0] salt,
      input logic [15:0] esalt, input logic [63:0] ehash);
    // leave valid low after each transfer; the block is busy then
    @(posedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk);
    in_ch.valid         <= 1'b1;
    in_ch.password_key  <= pkey;
    in_ch.salt          <= salt;
    in_ch.expected_salt <= esalt;
    in_ch.expected_hash <= ehash;
    hash_queue.push_back(compute_hash(pkey, salt, esalt, ehash, iter_cnt));
    n_sent++;
    do @(posedge clk); while (!in_ch.ready);
    in_ch.valid <= 1'b0;
  endtask

  // Send a request whose stored pair is the true hash, so that it matches.
  task automatic send_matching(input logic [63:0] pkey, input logic [15:0] salt);
    hash_result_t h;
    h = compute_hash(pkey, salt, salt, 64'h0, iter_cnt);
    send_request(pkey, salt, salt, h.hash_value);
  endtask

  task automatic drain();
    while (hash_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_iterations(input logic [7:0] n);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we   <= 1'b0;
    iter_cnt = n;
  endtask

  task automatic random_request();
    logic [63:0] pkey;
    logic [15:0] salt;
    pkey = rand64();
    salt = 16'($urandom());
    case ($urandom_range(3))
      0: send_matching(pkey, salt);
      1: send_request(pkey, salt, salt, rand64());
      2: begin
        hash_result_t h;
        h = compute_hash(pkey, salt, salt, 64'h0, iter_cnt);
        send_request(pkey, salt, salt ^ 16'(1 << $urandom_range(15)), h.hash_value);
      end
      default: send_request(pkey, salt, 16'($urandom()), rand64());
    endcase
  endtask

  task automatic test_directed();
    send_request(64'h0, 16'h0, 16'h0, 64'h0);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_matching(64'h7061_7373_776F_7264, 16'h1234);
    send_matching(64'h0, 16'hFFFF);
    send_matching(64'hFFFF_FFFF_FFFF_FFFF, 16'h0);
    send_request(64'h0101_0101_0101_0101, 16'hA55A, 16'h5AA5, 64'h0);
    send_request(64'h8000_0000_0000_0001, 16'h8001, 16'h8001, 64'h8000_0000_0000_0000);
  endtask

  task automatic test_iteration_counts();
    logic [7:0] counts [5] = '{8'd0, 8'd1, 8'd255, 8'd2, 8'd128};
    foreach (counts[i]) begin
      set_iterations(counts[i]);
      send_matching(64'h0123_4567_89AB_CDEF, 16'h0F0F);
      send_request(rand64(), 16'($urandom()), 16'($urandom()), rand64());
      send_matching(rand64(), 16'($urandom()));
    end
  endtask

  task automatic test_random_phases();
    int idle_set [4][2] = '{'{0, 0}, '{80, 0}, '{0, 80}, '{26, 26}};
    logic [7:0] counts [4] = '{8'd1, 8'd3, 8'd25, 8'd2};
    for (int ph = 0; ph < 4; ph++) begin
      set_iterations(counts[ph]);
      send_idle_pct  = idle_set[ph][0];
      recv_stall_pct = idle_set[ph][1];
      // Short counts carry most of the load; the default count only a few.
      repeat (ph == 2 ? 40 : 420) random_request();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    set_iterations(8'd1);
    hold_off = 300;
    repeat (8) random_request();
    drain();
    // Send further requests after the hold-off has run out, then drain.
    repeat (5) random_request();
    drain();
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = 8'd0;
    in_ch.valid         = 1'b0;
    in_ch.password_key  = 64'h0;
    in_ch.salt          = 16'h0;
    in_ch.expected_salt = 16'h0;
    in_ch.expected_hash = 64'h0;
    iter_cnt            = ITER_RESET;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    hold_off            = 0;
    errors              = 0;
    n_sent              = 0;
    n_checked           = 0;
    n_matched           = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_iteration_counts();
    test_backpressure();
    test_random_phases();
    drain();
    $display("Covered %0d requests (%0d matching) over iteration counts 0 to 255,",
             n_sent, n_matched);
    $display("with sender gaps, receiver stalls and a long output hold-off.");
    if (errors == 0) begin
      $display("salted_iterated_des_password_hash: match");
    end else begin
      $display("salted_iterated_des_password_hash: mismatch");
    end
    $finish;
  end

  // Receiver: random stalls, plus a counted hold-off to fill the block up.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        hold_off = hold_off - 1;
      end else begin
        out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    hash_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (hash_queue.size() == 0) begin
        $error("unexpected result hash_value=%h", out_ch.hash_value);
        errors++;
      end else begin
        want = hash_queue.pop_front();
        n_checked++;
        if (want.matches_res) n_matched++;
        if (out_ch.hash_value !== want.hash_value) begin
          $error("hash_value: expected %h, got %h", want.hash_value, out_ch.hash_value);
          errors++;
        end
        if (out_ch.matches_res !== want.matches_res) begin
          $error("matches_res: expected %0b, got %0b", want.matches_res,
                 out_ch.matches_res);
          errors++;
        end
      end
    end
  end

  initial begin
    #150_000_000;
    $display("salted_iterated_des_password_hash: mismatch");
    $finish;
  end
endmodule
